// ===== sv/sha256mh_pkg.sv =====
// ---------------------------------------------------------------------------
// sha256mh_pkg
// Shared types and constants of the SHA-256 message hasher: round constants,
// initial hash values, sequencer states and the core control/status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package sha256mh_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ROUNDS   = 64;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned HASH_WORDS = 8;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t PAD_MARK = 32'h8000_0000;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam word_t INIT_HASH [HASH_WORDS] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Sequencer to core
    typedef struct packed {
        logic       push;
        word_t      word;
        logic       clear_chain;
        logic [2:0] rd_index;
    } core_ctrl_t;

    // Core to sequencer
    typedef struct packed {
        logic       busy;
        logic [3:0] word_pos;
        word_t      rd_word;
    } core_status_t;

endpackage

`default_nettype wire

// ===== sv/sha256mh_core.sv =====
// ---------------------------------------------------------------------------
// sha256mh_core
// Block window, chaining state and one shared SHA-256 round unit that runs
// 64 rounds plus a feed-forward step per 512-bit block.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256mh_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire sha256mh_pkg::core_ctrl_t  ctrl,
    output sha256mh_pkg::core_status_t     status
);

    function automatic sha256mh_pkg::word_t rotr(input sha256mh_pkg::word_t x,
                                                 input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    sha256mh_pkg::word_t h_reg [sha256mh_pkg::HASH_WORDS];
    sha256mh_pkg::word_t v_reg [sha256mh_pkg::HASH_WORDS];
    sha256mh_pkg::word_t w_reg [sha256mh_pkg::BLK_WORDS];
    logic [3:0] wpos_reg;
    logic [5:0] round_reg;
    logic       busy_reg;
    logic       fin_reg;

    sha256mh_pkg::word_t big0, big1, ch, maj, t1, t2, sig0, sig1, w_new, shift_in;
    logic do_round, do_shift;

    always_comb begin
        big1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        big0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big1 + ch + sha256mh_pkg::ROUND_K[round_reg] + w_reg[0];
        t2    = big0 + maj;
        sig0  = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1  = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = sig1 + w_reg[9] + sig0 + w_reg[0];
        do_round = busy_reg && !fin_reg;
        do_shift = do_round || (!busy_reg && ctrl.push);
        shift_in = busy_reg ? w_new : ctrl.word;
    end

    // Control and chaining state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg     <= sha256mh_pkg::INIT_HASH;
            wpos_reg  <= '0;
            round_reg <= '0;
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end else if (busy_reg) begin
            if (fin_reg) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
                busy_reg <= 1'b0;
                fin_reg  <= 1'b0;
            end else begin
                round_reg <= 6'(round_reg + 6'd1);
                if (round_reg == 6'd63) begin
                    fin_reg <= 1'b1;
                end
            end
        end else begin
            if (ctrl.clear_chain) begin
                h_reg <= sha256mh_pkg::INIT_HASH;
            end
            if (ctrl.push) begin
                wpos_reg <= 4'(wpos_reg + 4'd1);
                if (wpos_reg == 4'd15) begin
                    busy_reg <= 1'b1;
                end
            end
        end
    end

    // Working variables and schedule window
    always_ff @(posedge aclk) begin
        if (do_shift) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= shift_in;
        end
        if (!busy_reg && ctrl.push && wpos_reg == 4'd15) begin
            v_reg <= h_reg;
        end else if (do_round) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign status.busy     = busy_reg;
    assign status.word_pos = wpos_reg;
    assign status.rd_word  = h_reg[ctrl.rd_index];

endmodule

`default_nettype wire

// ===== sv/sha256_message_hasher_top.sv =====
// ---------------------------------------------------------------------------
// sha256_message_hasher_top
// SHA-256 hasher: takes big-endian message words, pads the final block and
// returns the eight digest words.
// ---------------------------------------------------------------------------
//
//   channel | prefix | handshake        | carries
//   --------+--------+------------------+---------------------------------------
//   input   | s_     | s_valid/s_ready  | data_word, valid_bytes, last
//   result  | m_     | m_valid/m_ready  | digest_word, word_index, digest_last
//
// Flow: a message word is taken only while the sequencer waits for input and
// the round unit is idle. Every sixteenth word starts a compression (64 rounds
// on the one shared round unit plus a feed-forward step), and no word is taken
// until it ends. After the last word the sequencer pushes one pad word per
// cycle while the round unit is idle, runs one or two more compressions,
// then shows eight digest words, one per accepted cycle.
// Reset: aresetn low at a clock edge loads the initial hash values and clears
// the length, the word position and the sequencer. s_ready is low during a
// compression, during padding and while digest words wait; a stalled m_ready
// holds the current digest word.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_data_word,
    input  wire logic [2:0]  s_valid_bytes,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_digest_last
);

    sha256mh_pkg::state_t       state_reg, state_next;
    logic [63:0]                len_reg, len_next;
    logic                       pend80_reg, pend80_next;
    logic [2:0]                 idx_reg, idx_next;
    sha256mh_pkg::core_ctrl_t   ctrl;
    sha256mh_pkg::core_status_t status;

    logic                       accept;
    logic [2:0]                 nbytes;
    sha256mh_pkg::word_t        last_word;

    sha256mh_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .status  (status)
    );

    // Clamp the byte count and build the final word: keep the valid leading
    // bytes, drop the rest and, below four bytes, put the 0x80 marker after them.
    always_comb begin
        case (s_valid_bytes)
            3'd0:    nbytes = 3'd0;
            3'd1:    nbytes = 3'd1;
            3'd2:    nbytes = 3'd2;
            3'd3:    nbytes = 3'd3;
            default: nbytes = 3'd4;
        endcase
        case (nbytes)
            3'd0:    last_word = sha256mh_pkg::PAD_MARK;
            3'd1:    last_word = {s_data_word[31:24], 24'h80_0000};
            3'd2:    last_word = {s_data_word[31:16], 16'h8000};
            3'd3:    last_word = {s_data_word[31:8], 8'h80};
            default: last_word = s_data_word;
        endcase
    end

    assign accept = s_valid && s_ready;

    // Outputs of the sequencer
    always_comb begin
        s_ready          = 1'b0;
        m_valid          = 1'b0;
        ctrl.push        = 1'b0;
        ctrl.word        = '0;
        ctrl.clear_chain = 1'b0;
        ctrl.rd_index    = idx_reg;
        case (state_reg)
            sha256mh_pkg::ST_IDLE: begin
                s_ready   = !status.busy;
                ctrl.push = accept;
                ctrl.word = s_last ? last_word : s_data_word;
            end
            sha256mh_pkg::ST_PAD: begin
                ctrl.push = !status.busy;
                if (pend80_reg) begin
                    ctrl.word = sha256mh_pkg::PAD_MARK;
                end else if (status.word_pos == 4'd14) begin
                    ctrl.word = len_reg[63:32];
                end
            end
            sha256mh_pkg::ST_LEN: begin
                ctrl.push = !status.busy;
                ctrl.word = len_reg[31:0];
            end
            sha256mh_pkg::ST_OUT: begin
                m_valid          = 1'b1;
                ctrl.clear_chain = m_ready && idx_reg == 3'd7;
            end
            default: begin
            end
        endcase
    end

    // Next state of the sequencer
    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        pend80_next = pend80_reg;
        idx_next    = idx_reg;
        case (state_reg)
            sha256mh_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_last) begin
                        len_next    = len_reg + 64'({nbytes, 3'b000});
                        pend80_next = (nbytes == 3'd4);
                        state_next  = sha256mh_pkg::ST_PAD;
                    end else begin
                        len_next = len_reg + 64'd32;
                    end
                end
            end
            sha256mh_pkg::ST_PAD: begin
                if (!status.busy) begin
                    if (pend80_reg) begin
                        pend80_next = 1'b0;
                    end else if (status.word_pos == 4'd14) begin
                        state_next = sha256mh_pkg::ST_LEN;
                    end
                end
            end
            sha256mh_pkg::ST_LEN: begin
                if (!status.busy) begin
                    state_next = sha256mh_pkg::ST_DRAIN;
                end
            end
            sha256mh_pkg::ST_DRAIN: begin
                if (!status.busy) begin
                    idx_next   = '0;
                    state_next = sha256mh_pkg::ST_OUT;
                end
            end
            sha256mh_pkg::ST_OUT: begin
                if (m_ready) begin
                    idx_next = 3'(idx_reg + 3'd1);
                    if (idx_reg == 3'd7) begin
                        len_next   = '0;
                        state_next = sha256mh_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sha256mh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sha256mh_pkg::ST_IDLE;
            len_reg    <= '0;
            pend80_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            pend80_reg <= pend80_next;
            idx_reg    <= idx_next;
        end
    end

    assign m_digest_word = status.rd_word;
    assign m_word_index  = idx_reg;
    assign m_digest_last = (idx_reg == 3'd7);

endmodule

`default_nettype wire

// ===== sv/sha256mh_checker.sv =====
// ---------------------------------------------------------------------------
// sha256mh_checker
// Port-level checks on the digest word sequence of the hasher and on s_ready.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256mh_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_digest_word,
    input wire logic [2:0]  m_word_index,
    input wire logic        m_digest_last
);

    a_last_on_seventh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digest_last == (m_word_index == 3'd7)))
        else $error("digest_last does not match word index");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word) && $stable(m_word_index))
        else $error("digest word changed while stalled");

    a_index_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_digest_last |=>
            m_valid && m_word_index == 3'($past(m_word_index) + 3'd1))
        else $error("digest words not in order");

    a_no_input_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while digest pending");

    a_end_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_digest_last |=> !m_valid)
        else $error("extra digest word after the last");

endmodule

bind sha256_message_hasher_top sha256mh_checker u_sha256mh_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_digest_last (m_digest_last)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top - testbench for sha256_message_hasher_top
// Streams directed messages and ones of random length and content into the
// hasher under random bursts and stalls, hashes each accepted word in a local
// SHA-256 model and checks every digest word that comes back against it.
// ---------------------------------------------------------------------------

module tb_top;

    typedef sha256mh_pkg::word_t word_t;

    // Idle cycles with no handshake on either channel before the run is
    // declared hung. The slowest legal wait is a two-block finish (padding
    // plus two compressions) behind a stalled receiver.
    localparam int HANG_LIMIT   = 3000;
    // Quiet cycles after the last digest word: long enough for a stray
    // extra result to show up.
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_WORDS = 300;

    localparam word_t PAD_WORD = 32'h8000_0000;
    localparam word_t PAD_BYTE = 32'h0000_0080;

    localparam word_t SHA_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam word_t SHA_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // One message word as it goes on the input channel.
    typedef struct packed {
        word_t      data;
        logic [2:0] nbytes;
        logic       is_last;
    } msg_word_t;

    // One digest word as it should come off the result channel.
    typedef struct packed {
        word_t      value;
        logic [2:0] index;
        logic       is_tail;
    } digest_beat_t;

    // Receiver stall behavior, picked anew at random for each segment of the run.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN
    } rx_mode_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word   = '0;
    logic [2:0]  s_valid_bytes = '0;
    logic        s_last        = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_digest_last;

    sha256_message_hasher_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_valid_bytes (s_valid_bytes),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_digest_last (m_digest_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Local SHA-256 model: chaining state, block being filled, bit count.
    // -----------------------------------------------------------------------
    word_t        hash_state [8] = SHA_IV;
    word_t        msg_block  [16];
    logic [63:0]  msg_bits  = '0;
    logic [3:0]   blk_fill  = '0;

    msg_word_t    words_to_send [$];
    digest_beat_t digest_due    [$];
    int           mismatches = 0;

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over the full block and fold into the chain.
    task automatic compress_block();
        word_t sched [64];
        word_t v [8];
        word_t t1;
        word_t t2;
        for (int i = 0; i < 16; i++)
            sched[i] = msg_block[i];
        for (int i = 16; i < 64; i++) begin
            sched[i] = sched[i-16] + sched[i-7]
                     + (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
                     + (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + sched[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endtask

    // Append one word to the block; compress when the sixteenth lands.
    task automatic append_block_word(input word_t w);
        msg_block[blk_fill] = w;
        blk_fill = blk_fill + 4'd1;
        if (blk_fill == 4'd0)
            compress_block();
    endtask

    // Take one accepted message word; on the final word pad, finish the
    // hash, queue the eight digest words and start over from the IV.
    task automatic hash_msg_word(input word_t data, input logic [2:0] nbytes,
                                 input logic is_last);
        int    nb;
        word_t keep;
        if (!is_last) begin
            // Byte count is don't-care on inner words: all four bytes count.
            msg_bits = msg_bits + 64'd32;
            append_block_word(data);
            return;
        end
        nb = (nbytes > 3'd4) ? 4 : int'(nbytes);
        msg_bits = msg_bits + 64'(nb * 8);
        if (nb == 4) begin
            append_block_word(data);
            append_block_word(PAD_WORD);
        end else begin
            // Drop the trailing invalid bytes, put the pad byte right after.
            keep = '1;
            keep = (nb == 0) ? '0 : keep << (32 - 8 * nb);
            append_block_word((data & keep) | (PAD_BYTE << (24 - 8 * nb)));
        end
        // No room for the length: close this block and pad a second one.
        if (blk_fill == 4'd15)
            append_block_word('0);
        while (blk_fill < 4'd14)
            append_block_word('0);
        append_block_word(msg_bits[63:32]);
        append_block_word(msg_bits[31:0]);
        for (int i = 0; i < 8; i++)
            digest_due.push_back('{hash_state[i], 3'(i), (i == 7)});
        hash_state = SHA_IV;
        msg_bits   = '0;
        blk_fill   = '0;
    endtask

    // Queue one message: n_full inner words, then the final word. Inner
    // words of a noisy message now and then carry a byte count other than four.
    task automatic queue_message(input int n_full, input logic [2:0] tail_bytes,
                                 input bit noisy);
        logic [2:0] nb;
        for (int i = 0; i < n_full; i++) begin
            nb = (noisy && $urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            words_to_send.push_back('{word_t'($urandom), nb, 1'b0});
        end
        words_to_send.push_back('{word_t'($urandom), tail_bytes, 1'b1});
    endtask

    // -----------------------------------------------------------------------
    // Driver: feed the input channel in bursts with random gaps. Hold a word
    // on the bus until it is taken; hash it in the model the edge it goes.
    // -----------------------------------------------------------------------
    int        burst_left = 0;
    int        gap_left   = 0;
    msg_word_t next_word;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready)
                hash_msg_word(s_data_word, s_valid_bytes, s_last);
            // Bus is free when nothing is up or the word just went.
            if (!s_valid || s_ready) begin
                if (gap_left != 0 || words_to_send.size() == 0) begin
                    if (gap_left != 0)
                        gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    next_word = words_to_send.pop_front();
                    s_data_word   <= next_word.data;
                    s_valid_bytes <= next_word.nbytes;
                    s_last        <= next_word.is_last;
                    s_valid       <= 1'b1;
                    // End of burst: pick the gap and the next burst length.
                    // A quarter of gaps are zero, so bursts run back to back.
                    if (burst_left <= 1) begin
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 20);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: stall on a mode picked anew for each segment - always ready,
    // coin flip, or a rotating random bit pattern (never all zeros).
    // -----------------------------------------------------------------------
    rx_mode_t    rx_mode  = RX_ALWAYS;
    logic [31:0] stall_pat = '1;
    int          seg_left  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            seg_left = 0;
        end else begin
            if (seg_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                stall_pat = $urandom | 32'h1;
                seg_left  = 23;
            end else begin
                seg_left--;
            end
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                default: begin
                    m_ready   <= stall_pat[0];
                    stall_pat = {stall_pat[0], stall_pat[31:1]};
                end
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: compare every accepted digest word with the oldest one due.
    // -----------------------------------------------------------------------
    digest_beat_t due;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_due.size() == 0) begin
                $display("%0t: unexpected digest word %h index %0d",
                         $time, m_digest_word, m_word_index);
                mismatches++;
            end else begin
                due = digest_due.pop_front();
                if (m_digest_word !== due.value) begin
                    $display("%0t: digest_word[%0d] expected %h, got %h",
                             $time, due.index, due.value, m_digest_word);
                    mismatches++;
                end
                if (m_word_index !== due.index) begin
                    $display("%0t: word_index expected %0d, got %0d",
                             $time, due.index, m_word_index);
                    mismatches++;
                end
                if (m_digest_last !== due.is_tail) begin
                    $display("%0t: digest_last[%0d] expected %b, got %b",
                             $time, due.index, due.is_tail, m_digest_last);
                    mismatches++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: count cycles with no handshake on either side.
    // -----------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
            $display("** sha256_message_hasher_top: FAILED **");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run.
    // -----------------------------------------------------------------------
    int sent_random;
    int n_full;
    logic [2:0] tail_bytes;

    initial begin
        // Empty message; the junk data must not leak into the hash.
        words_to_send.push_back('{32'hFFFF_FFFF, 3'd0, 1'b1});
        // Byte count above four on the final word saturates to four.
        words_to_send.push_back('{32'hA5C3_0F96, 3'd7, 1'b1});
        // "abc" with a junk low byte.
        words_to_send.push_back('{32'h6162_63FF, 3'd3, 1'b1});
        // One and two valid bytes.
        words_to_send.push_back('{32'hFFFF_FFFF, 3'd1, 1'b1});
        words_to_send.push_back('{32'h0000_0000, 3'd2, 1'b1});
        // Inner words with odd byte counts still take all four bytes.
        words_to_send.push_back('{32'h0000_0000, 3'd0, 1'b0});
        words_to_send.push_back('{32'hFFFF_FFFF, 3'd6, 1'b0});
        words_to_send.push_back('{32'h8000_0001, 3'd5, 1'b1});
        // Full final word at slot 13: the pad word lands in slot 14, so the
        // length goes into a second block.
        queue_message(13, 3'd4, 1'b0);

        // Random messages: mostly short, some across several blocks. Lengths
        // near a block boundary hit both one- and two-block finishes.
        sent_random = 0;
        while (sent_random < RANDOM_WORDS) begin
            n_full     = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 40)
                                                     : $urandom_range(0, 17);
            tail_bytes = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
            queue_message(n_full, tail_bytes, 1'b1);
            sent_random += n_full + 1;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the last word to go and every digest word to come back.
        while (words_to_send.size() != 0 || s_valid || digest_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("** sha256_message_hasher_top: PASSED **");
        else
            $display("** sha256_message_hasher_top: FAILED **");
        $finish;
    end

endmodule
